[rtl/mbe_pkg.sv]
// Shared constants, configuration register codes and multiplier control types
// for the Mandelbrot escape-time pixel colour block. No dependencies.
`default_nettype none

package mbe_pkg;

    localparam int FRAC_BITS_DEF = 28;
    localparam int COORD_BITS    = 10;

    localparam int COORD_W   = COORD_BITS;
    localparam int ITER_W    = 10;
    localparam int DIM_W     = 11;
    localparam int COLOR_W   = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DIM_W;

    localparam int HUE_SECTOR = 43;
    localparam int HUE_SCALE  = 6;

    localparam int S_FIELDS_W = 2 * COORD_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

    localparam int ITER_LO    = 2 * COORD_W;
    localparam int RED_LO     = ITER_LO + ITER_W;
    localparam int M_FIELDS_W = RED_LO + 3 * COLOR_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_ITER = 2'd0,
        REG_CANVAS_W = 2'd1,
        REG_CANVAS_H = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic start;
        logic neg;
        logic dbl;
    } t_mul_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_sts;

endpackage

`default_nettype wire

[rtl/mbe_mul.sv]
// Shared fixed-point multiplier: magnitude product over 32-bit-or-less limbs,
// sign applied and floor shift by FRAC_BITS (or FRAC_BITS-1). Uses mbe_pkg.
`default_nettype none

module mbe_mul import mbe_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_mul_ctl                  i_ctl,
    input  wire logic [FRAC_BITS:0]        i_a,
    input  wire logic [FRAC_BITS:0]        i_b,
    output t_mul_sts                       o_sts,
    output logic signed [FRAC_BITS+4:0]    o_res
);

    localparam int MAGW  = FRAC_BITS + 1;
    localparam int NLIMB = (MAGW + 31) / 32;
    localparam int LIMB  = (MAGW + NLIMB - 1) / NLIMB;
    localparam int PADW  = NLIMB * LIMB;
    localparam int PRODW = 2 * PADW;
    localparam int IW    = (NLIMB > 1) ? $clog2(NLIMB) : 1;
    localparam int VW    = FRAC_BITS + 5;
    localparam logic [IW-1:0] LAST = IW'(NLIMB - 1);

    logic [PADW-1:0]       r_a;
    logic [PADW-1:0]       r_b;
    logic [IW-1:0]         r_i;
    logic [IW-1:0]         r_j;
    logic                  r_busy;
    logic [2*LIMB-1:0]     r_pp;
    logic [IW:0]           r_pp_pos;
    logic                  r_pp_vld;
    logic                  r_pp_last;
    logic [PRODW-1:0]      r_acc;
    logic                  r_fin;
    logic                  r_neg;
    logic                  r_dbl;
    logic                  r_done;
    logic signed [VW-1:0]  r_res;

    logic signed [PRODW:0] w_sp;
    logic signed [PRODW:0] w_sh;

    always_comb begin
        w_sp = r_neg ? -$signed({1'b0, r_acc}) : $signed({1'b0, r_acc});
        w_sh = r_dbl ? (w_sp >>> (FRAC_BITS - 1)) : (w_sp >>> FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_pp_vld  <= 1'b0;
            r_pp_last <= 1'b0;
            r_fin     <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_pp_vld  <= r_busy;
            r_pp_last <= r_busy && (r_i == LAST) && (r_j == LAST);
            r_fin     <= r_pp_vld && r_pp_last;
            r_done    <= r_fin;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_i == LAST) && (r_j == LAST)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pp     <= r_a[r_i*LIMB +: LIMB] * r_b[r_j*LIMB +: LIMB];
        r_pp_pos <= {1'b0, r_i} + {1'b0, r_j};
        if (r_pp_vld) begin
            r_acc <= r_acc + (PRODW'(r_pp) << (LIMB * r_pp_pos));
        end
        if (r_busy) begin
            if (r_j == LAST) begin
                r_j <= '0;
                r_i <= r_i + 1'b1;
            end else begin
                r_j <= r_j + 1'b1;
            end
        end
        if (r_fin) begin
            r_res <= w_sh[VW-1:0];
        end
        if (i_ctl.start) begin
            r_a   <= PADW'(i_a);
            r_b   <= PADW'(i_b);
            r_neg <= i_ctl.neg;
            r_dbl <= i_ctl.dbl;
            r_i   <= '0;
            r_j   <= '0;
            r_acc <= '0;
        end
    end

    assign o_sts = '{busy: r_busy | r_pp_vld | r_fin, done: r_done};
    assign o_res = r_res;

endmodule

`default_nettype wire

[rtl/mandelbrot_escape_pixel_colour.sv]
// Top level of the Mandelbrot escape-time pixel color block: sequencer,
// shared restoring divider, iteration datapath and HSV color stages.
// Depends on mbe_pkg and mbe_mul.
//
// One pixel request is taken at a time; o_s_tready is high only while the
// sequencer is idle, and a finished result waits in the output register
// without holding up the next request. The plane coordinates come one after
// the other from one bit-serial divider. Each iteration of z = z*z + c takes
// three products in the shared multiplier, x*x, y*y and 2*x*y, each built
// from K*K limb products, where K is 1 for FRAC_BITS up to 31 and 2 from 32
// to 63. An escaped pixel then goes from the range check through the same
// divider for its level and on through the color states S_HSV0 to S_HSV3
// and S_OUT; a pixel inside the set goes from the check straight to S_OUT.
// An escape can also be found at the sum of the squares rather than at the
// range check, after x*x and y*y but before 2*x*y.
`default_nettype none

module mandelbrot_escape_pixel_colour import mbe_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wen,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // pixel_col, pixel_row
    input  wire logic [S_TDATA_W-1:0]  i_s_tdata,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // out_col, out_row, iterations, red, green, blue
    output logic [M_TDATA_W-1:0]       o_m_tdata,
    // escaped
    output logic [0:0]                 o_m_tuser
);

    localparam int VW     = FRAC_BITS + 5;
    localparam int MAGW   = FRAC_BITS + 1;
    localparam int QW     = FRAC_BITS + 2;
    localparam int CW     = $clog2(QW);
    localparam int HALF_W = DIM_W - 1;
    localparam int LVL_W  = ITER_W + 8;

    localparam logic signed [VW-1:0] TWO_FX     = VW'(1) << (FRAC_BITS + 1);
    localparam logic signed [VW-1:0] NEG_TWO_FX = -TWO_FX;
    localparam logic signed [VW-1:0] FOUR_FX    = VW'(1) << (FRAC_BITS + 2);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_DIV, S_STORE, S_CHECK, S_MUL_XX, S_MUL_YY, S_MUL_XY,
        S_HSV0, S_HSV1, S_HSV2, S_HSV3, S_OUT
    } t_state;

    typedef enum logic [1:0] {P_RE, P_IM, P_LVL} t_phase;

    t_state                r_state;
    t_phase                r_phase;
    logic [ITER_W-1:0]     r_max_iter;
    logic [DIM_W-1:0]      r_canvas_w;
    logic [DIM_W-1:0]      r_canvas_h;
    logic [COORD_W-1:0]    r_col;
    logic [COORD_W-1:0]    r_row;
    logic [DIM_W-1:0]      r_rem_div;
    logic [QW-1:0]         r_quo;
    logic [CW-1:0]         r_cnt;
    logic                  r_sat;
    logic                  r_neg;
    logic signed [VW-1:0]  r_cre;
    logic signed [VW-1:0]  r_cim;
    logic signed [VW-1:0]  r_x;
    logic signed [VW-1:0]  r_y;
    logic signed [VW-1:0]  r_xx;
    logic signed [VW-1:0]  r_yy;
    logic [ITER_W-1:0]     r_iter;
    logic                  r_esc;
    logic [COLOR_W-1:0]    r_level;
    logic [2:0]            r_region;
    logic [COLOR_W-1:0]    r_crem;
    logic [COLOR_W-1:0]    r_p;
    logic [COLOR_W-1:0]    r_sq;
    logic [COLOR_W-1:0]    r_st;
    logic [COLOR_W-1:0]    r_q;
    logic [COLOR_W-1:0]    r_t;
    logic [COLOR_W-1:0]    r_red;
    logic [COLOR_W-1:0]    r_green;
    logic [COLOR_W-1:0]    r_blue;
    logic                  r_out_valid;
    logic [M_TDATA_W-1:0]  r_m_tdata;
    logic                  r_m_tuser;

    logic [DIM_W-1:0]      w_divisor;
    logic [DIM_W:0]        w_trial;
    logic [DIM_W:0]        w_diff;
    logic                  w_ge;
    logic [DIM_W-1:0]      n_rem_div;
    logic [QW-1:0]         n_quo;
    logic [HALF_W-1:0]     w_pos;
    logic [HALF_W-1:0]     w_half;
    logic                  w_pneg;
    logic [HALF_W-1:0]     w_m;
    logic [LVL_W-1:0]      w_lvl_num;
    logic signed [VW-1:0]  w_cmag;
    logic signed [VW-1:0]  w_coord;
    logic                  w_run;
    logic                  w_big;
    logic signed [VW-1:0]  w_xabs;
    logic signed [VW-1:0]  w_yabs;
    logic signed [VW-1:0]  w_sum;
    logic                  w_sum_lt;
    logic [2:0]            w_region;
    logic [COLOR_W-1:0]    w_base;
    logic [COLOR_W-1:0]    w_diff_h;
    logic [2*COLOR_W-1:0]  w_pm;
    logic [2*COLOR_W-1:0]  w_sqm;
    logic [2*COLOR_W-1:0]  w_stm;
    logic [2*COLOR_W-1:0]  w_qm;
    logic [2*COLOR_W-1:0]  w_tm;

    t_mul_ctl              w_mul_ctl;
    t_mul_sts              w_mul_sts;
    logic [MAGW-1:0]       w_mul_a;
    logic [MAGW-1:0]       w_mul_b;
    logic signed [VW-1:0]  w_mul_res;

    mbe_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mul_ctl),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_sts   (w_mul_sts),
        .o_res   (w_mul_res)
    );

    // restoring divider step, shared by both coordinates and the level
    always_comb begin
        w_divisor = (r_phase == P_LVL) ? DIM_W'(r_max_iter) : r_canvas_w;
        w_trial   = {r_rem_div, r_quo[QW-1]};
        w_ge      = w_trial >= {1'b0, w_divisor};
        w_diff    = w_trial - {1'b0, w_divisor};
        n_rem_div = w_ge ? w_diff[DIM_W-1:0] : w_trial[DIM_W-1:0];
        n_quo     = {r_quo[QW-2:0], w_ge};
    end

    always_comb begin
        if (r_phase == P_IM) begin
            w_pos  = HALF_W'(r_row);
            w_half = r_canvas_h[DIM_W-1:1];
        end else begin
            w_pos  = HALF_W'(r_col);
            w_half = r_canvas_w[DIM_W-1:1];
        end
        w_pneg    = w_pos < w_half;
        w_m       = w_pneg ? (w_half - w_pos) : (w_pos - w_half);
        w_lvl_num = {r_iter, 8'b0} - LVL_W'(r_iter);
        w_cmag    = r_sat ? FOUR_FX : $signed(VW'(r_quo));
        w_coord   = r_neg ? -w_cmag : w_cmag;
    end

    always_comb begin
        w_run    = r_iter < r_max_iter;
        w_big    = (r_x >= TWO_FX) || (r_x <= NEG_TWO_FX) ||
                   (r_y >= TWO_FX) || (r_y <= NEG_TWO_FX);
        w_xabs   = r_x[VW-1] ? -r_x : r_x;
        w_yabs   = r_y[VW-1] ? -r_y : r_y;
        w_sum    = r_xx + w_mul_res;
        w_sum_lt = w_sum < FOUR_FX;
    end

    always_comb begin
        w_mul_ctl = '0;
        w_mul_a   = w_xabs[MAGW-1:0];
        w_mul_b   = w_xabs[MAGW-1:0];
        unique case (r_state)
            S_CHECK: begin
                w_mul_ctl.start = w_run && !w_big;
            end
            S_MUL_XX: begin
                w_mul_ctl.start = w_mul_sts.done;
                w_mul_a         = w_yabs[MAGW-1:0];
                w_mul_b         = w_yabs[MAGW-1:0];
            end
            S_MUL_YY: begin
                w_mul_ctl.start = w_mul_sts.done && w_sum_lt;
                w_mul_ctl.neg   = r_x[VW-1] ^ r_y[VW-1];
                w_mul_ctl.dbl   = 1'b1;
                w_mul_b         = w_yabs[MAGW-1:0];
            end
            default: begin
            end
        endcase
    end

    // color arithmetic, h = s = v = level
    always_comb begin
        if (r_level >= COLOR_W'(5 * HUE_SECTOR)) begin
            w_region = 3'd5;
        end else if (r_level >= COLOR_W'(4 * HUE_SECTOR)) begin
            w_region = 3'd4;
        end else if (r_level >= COLOR_W'(3 * HUE_SECTOR)) begin
            w_region = 3'd3;
        end else if (r_level >= COLOR_W'(2 * HUE_SECTOR)) begin
            w_region = 3'd2;
        end else if (r_level >= COLOR_W'(HUE_SECTOR)) begin
            w_region = 3'd1;
        end else begin
            w_region = 3'd0;
        end
        w_base   = COLOR_W'(w_region * HUE_SECTOR);
        w_diff_h = COLOR_W'((r_level - w_base) * HUE_SCALE);
        w_pm     = r_level * (8'd255 - r_level);
        w_sqm    = r_level * r_crem;
        w_stm    = r_level * (8'd255 - r_crem);
        w_qm     = r_level * (8'd255 - r_sq);
        w_tm     = r_level * (8'd255 - r_st);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= P_RE;
            r_max_iter  <= ITER_W'(50);
            r_canvas_w  <= DIM_W'(128);
            r_canvas_h  <= DIM_W'(64);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                unique case (t_cfg_reg'(i_cfg_idx))
                    REG_MAX_ITER: r_max_iter <= i_cfg_data[ITER_W-1:0];
                    REG_CANVAS_W: r_canvas_w <= i_cfg_data;
                    REG_CANVAS_H: r_canvas_h <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (r_out_valid && i_m_tready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_col   <= i_s_tdata[COORD_W-1:0];
                        r_row   <= i_s_tdata[2*COORD_W-1:COORD_W];
                        r_phase <= P_RE;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (r_phase == P_LVL) begin
                        r_rem_div <= '0;
                        r_quo     <= QW'(w_lvl_num);
                    end else begin
                        r_rem_div <= DIM_W'(w_m);
                        r_quo     <= '0;
                        r_sat     <= DIM_W'(w_m) >= r_canvas_w;
                        r_neg     <= w_pneg;
                    end
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem_div <= n_rem_div;
                    r_quo     <= n_quo;
                    r_cnt     <= r_cnt + 1'b1;
                    if (r_cnt == CW'(QW - 1)) begin
                        r_state <= S_STORE;
                    end
                end
                S_STORE: begin
                    unique case (r_phase)
                        P_RE: begin
                            r_cre   <= w_coord;
                            r_phase <= P_IM;
                            r_state <= S_LOAD;
                        end
                        P_IM: begin
                            r_cim   <= w_coord;
                            r_x     <= '0;
                            r_y     <= '0;
                            r_iter  <= '0;
                            r_state <= S_CHECK;
                        end
                        default: begin
                            r_level <= r_quo[COLOR_W-1:0];
                            r_state <= S_HSV0;
                        end
                    endcase
                end
                S_CHECK: begin
                    if (!w_run) begin
                        r_esc   <= 1'b0;
                        r_state <= S_OUT;
                    end else if (w_big) begin
                        r_esc   <= 1'b1;
                        r_phase <= P_LVL;
                        r_state <= S_LOAD;
                    end else begin
                        r_state <= S_MUL_XX;
                    end
                end
                S_MUL_XX: begin
                    if (w_mul_sts.done) begin
                        r_xx    <= w_mul_res;
                        r_state <= S_MUL_YY;
                    end
                end
                S_MUL_YY: begin
                    if (w_mul_sts.done) begin
                        r_yy <= w_mul_res;
                        if (w_sum_lt) begin
                            r_state <= S_MUL_XY;
                        end else begin
                            r_esc   <= 1'b1;
                            r_phase <= P_LVL;
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_MUL_XY: begin
                    if (w_mul_sts.done) begin
                        r_x     <= r_xx - r_yy + r_cre;
                        r_y     <= w_mul_res + r_cim;
                        r_iter  <= r_iter + 1'b1;
                        r_state <= S_CHECK;
                    end
                end
                S_HSV0: begin
                    r_region <= w_region;
                    r_crem   <= w_diff_h;
                    r_p      <= w_pm[2*COLOR_W-1:COLOR_W];
                    r_state  <= S_HSV1;
                end
                S_HSV1: begin
                    r_sq    <= w_sqm[2*COLOR_W-1:COLOR_W];
                    r_st    <= w_stm[2*COLOR_W-1:COLOR_W];
                    r_state <= S_HSV2;
                end
                S_HSV2: begin
                    r_q     <= w_qm[2*COLOR_W-1:COLOR_W];
                    r_t     <= w_tm[2*COLOR_W-1:COLOR_W];
                    r_state <= S_HSV3;
                end
                S_HSV3: begin
                    if (r_level == '0) begin
                        r_red   <= '0;
                        r_green <= '0;
                        r_blue  <= '0;
                    end else begin
                        case (r_region)
                            3'd0: begin
                                r_red <= r_level; r_green <= r_t; r_blue <= r_p;
                            end
                            3'd1: begin
                                r_red <= r_q; r_green <= r_level; r_blue <= r_p;
                            end
                            3'd2: begin
                                r_red <= r_p; r_green <= r_level; r_blue <= r_t;
                            end
                            3'd3: begin
                                r_red <= r_p; r_green <= r_q; r_blue <= r_level;
                            end
                            3'd4: begin
                                r_red <= r_t; r_green <= r_p; r_blue <= r_level;
                            end
                            default: begin
                                r_red <= r_level; r_green <= r_p; r_blue <= r_q;
                            end
                        endcase
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_m_tdata   <= {{M_PAD_W{1'b0}},
                                        r_esc ? r_blue  : {COLOR_W{1'b0}},
                                        r_esc ? r_green : {COLOR_W{1'b0}},
                                        r_esc ? r_red   : {COLOR_W{1'b0}},
                                        r_iter, r_row, r_col};
                        r_m_tuser   <= r_esc;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready   = (r_state == S_IDLE);
    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = r_m_tdata;
    assign o_m_tuser[0] = r_m_tuser;

    a_accept_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == S_LOAD) && (r_phase == P_RE))
        else $error("request not followed by real-part load");

    a_mul_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_ctl.start |-> !w_mul_sts.busy)
        else $error("multiplier started while busy");

    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_sts.done |->
            (r_state == S_MUL_XX) || (r_state == S_MUL_YY) || (r_state == S_MUL_XY))
        else $error("multiplier result with no waiting step");

    a_square_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL_YY) && w_mul_sts.done |-> !w_mul_res[VW-1] && !r_xx[VW-1])
        else $error("negative square");

    a_operand_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL_XX) |-> (r_x < TWO_FX) && (r_x > NEG_TWO_FX))
        else $error("real part out of range at multiply");

    a_inside_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata[RED_LO +: 3*COLOR_W] == '0))
        else $error("color on pixel inside the set");

endmodule

`default_nettype wire

[sim/mandelbrot_pixel_checker.sv]
// Checker for the Mandelbrot escape-time pixel color block: tracks register writes,
// predicts the result of every accepted pixel request and compares each output in order.
// Depends on mbe_pkg.
module mandelbrot_pixel_checker import mbe_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    // pixel_col, pixel_row
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    // out_col, out_row, iterations, red, green, blue
    input  logic [M_TDATA_W-1:0]  i_m_tdata,
    // escaped
    input  logic [0:0]            i_m_tuser,
    output int                    o_errors,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     FRAC = FRAC_BITS_DEF;
    localparam longint TWO  = longint'(1) << (FRAC + 1);
    localparam longint FOUR = longint'(1) << (FRAC + 2);

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               escaped;
        logic [ITER_W-1:0]  iters;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_pixel;

    logic [ITER_W-1:0] iter_limit = 10'd50;
    logic [DIM_W-1:0]  canvas_w   = 11'd128;
    logic [DIM_W-1:0]  canvas_h   = 11'd64;
    t_pixel            awaited_pixels[$];
    t_pixel            got;
    t_pixel            want;
    int                err_count  = 0;

    // trunc((pos - half) * 4 / span), saturated to +-4
    function automatic longint plane_point(int unsigned pos, int unsigned half,
                                           int unsigned span);
        int unsigned offset;
        longint      mag;
        offset = (pos < half) ? half - pos : pos - half;
        if (offset >= span)
            mag = longint'(4) << FRAC;
        else
            mag = (longint'(offset) << (FRAC + 2)) / longint'(span);
        return (pos < half) ? -mag : mag;
    endfunction

    function automatic t_pixel escape_colour(logic [COORD_W-1:0] col,
                                             logic [COORD_W-1:0] row);
        longint      c_re, c_im, x, y, xx, yy, xy;
        int unsigned n, v, region, rem, p, q, t;
        t_pixel      px;
        c_re = plane_point(col, canvas_w / 2, canvas_w);
        c_im = plane_point(row, canvas_h / 2, canvas_w);
        x = 0;
        y = 0;
        n = 0;
        while (n < iter_limit) begin
            if (x >= TWO || x <= -TWO || y >= TWO || y <= -TWO)
                break;
            xx = (x * x) >>> FRAC;
            yy = (y * y) >>> FRAC;
            if (xx + yy >= FOUR)
                break;
            xy = (x * y) >>> (FRAC - 1);
            x = xx - yy + c_re;
            y = xy + c_im;
            n++;
        end
        px = '0;
        px.col = col;
        px.row = row;
        px.iters = ITER_W'(n);
        px.escaped = (n < iter_limit);
        // level is hue, saturation and value at once; level zero is black
        if (px.escaped) begin
            v = (255 * n) / iter_limit;
            region = v / HUE_SECTOR;
            rem = (v - region * HUE_SECTOR) * HUE_SCALE;
            p = (v * (255 - v)) >> 8;
            q = (v * (255 - ((v * rem) >> 8))) >> 8;
            t = (v * (255 - ((v * (255 - rem)) >> 8))) >> 8;
            if (v == 0)
                {px.red, px.green, px.blue} = '0;
            else begin
                case (region)
                    0: {px.red, px.green, px.blue} = {8'(v), 8'(t), 8'(p)};
                    1: {px.red, px.green, px.blue} = {8'(q), 8'(v), 8'(p)};
                    2: {px.red, px.green, px.blue} = {8'(p), 8'(v), 8'(t)};
                    3: {px.red, px.green, px.blue} = {8'(p), 8'(q), 8'(v)};
                    4: {px.red, px.green, px.blue} = {8'(t), 8'(p), 8'(v)};
                    default: {px.red, px.green, px.blue} = {8'(v), 8'(p), 8'(q)};
                endcase
            end
        end
        return px;
    endfunction

    task automatic compare_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            iter_limit = 10'd50;
            canvas_w = 11'd128;
            canvas_h = 11'd64;
            awaited_pixels.delete();
        end else begin
            if (i_cfg_wen) begin
                case (i_cfg_idx)
                    REG_MAX_ITER: iter_limit = i_cfg_data[ITER_W-1:0];
                    REG_CANVAS_W: canvas_w = i_cfg_data;
                    REG_CANVAS_H: canvas_h = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got.col = i_m_tdata[0 +: COORD_W];
                got.row = i_m_tdata[COORD_W +: COORD_W];
                got.iters = i_m_tdata[ITER_LO +: ITER_W];
                got.red = i_m_tdata[RED_LO +: COLOR_W];
                got.green = i_m_tdata[RED_LO + COLOR_W +: COLOR_W];
                got.blue = i_m_tdata[RED_LO + 2 * COLOR_W +: COLOR_W];
                got.escaped = i_m_tuser[0];
                if (awaited_pixels.size() == 0) begin
                    $error("result for pixel (%0d, %0d) with no request outstanding",
                           got.col, got.row);
                    err_count++;
                end else begin
                    want = awaited_pixels.pop_front();
                    compare_field("out_col", want.col, got.col);
                    compare_field("out_row", want.row, got.row);
                    compare_field("escaped", want.escaped, got.escaped);
                    compare_field("iterations", want.iters, got.iters);
                    compare_field("red", want.red, got.red);
                    compare_field("green", want.green, got.green);
                    compare_field("blue", want.blue, got.blue);
                end
            end
            if (i_s_tvalid && i_s_tready)
                awaited_pixels.push_back(escape_colour(i_s_tdata[0 +: COORD_W],
                                                       i_s_tdata[COORD_W +: COORD_W]));
        end
        o_errors <= err_count;
        o_pending <= awaited_pixels.size();
    end

endmodule

[sim/mandelbrot_escape_pixel_colour_test.sv]
// Testbench top for mandelbrot_escape_pixel_colour: clock, reset, register writes, pixel
// requests and result back-pressure, plus the verdict. Depends on mbe_pkg, the block
// and mandelbrot_pixel_checker.
module mandelbrot_escape_pixel_colour_test import mbe_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_CYCLES = 70000;
    localparam int HOLD_CYCLES     = 3000;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  cfg_wen  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [0:0]            m_tuser;
    int                    errors;
    int                    pending;
    int                    hold_len  = 0;
    bit                    tx_jitter = 1'b0;
    bit                    rx_jitter = 1'b0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    mandelbrot_escape_pixel_colour u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_wen  (cfg_wen),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    mandelbrot_pixel_checker u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_wen  (cfg_wen),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tuser  (m_tuser),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 20);
        return $urandom_range(30, 150);
    endfunction

    function automatic int unsigned pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return $urandom_range(8, 256);
        else if (r < 90)
            return $urandom_range(1, 1024);
        return $urandom_range(0, 2047);
    endfunction

    // mostly inside the canvas, some anywhere in the coordinate range
    function automatic int unsigned pick_coord(int unsigned dim);
        if (dim == 0 || $urandom_range(0, 99) < 15)
            return $urandom_range(0, 1023);
        return $urandom_range(0, ((dim > 1024) ? 1024 : dim) - 1);
    endfunction

    task automatic send_pixel(input int unsigned col, input int unsigned row);
        int gap;
        gap = tx_jitter ? idle_len() : 0;
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata = '0;
        s_tdata[0 +: COORD_W] = COORD_W'(col);
        s_tdata[COORD_W +: COORD_W] = COORD_W'(row);
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input int unsigned val);
        @(negedge clk);
        cfg_wen = 1'b1;
        cfg_idx = idx;
        cfg_data = CFG_DATA_W'(val);
        @(negedge clk);
        cfg_wen = 1'b0;
    endtask

    task automatic set_canvas(input int unsigned lim, input int unsigned w,
                              input int unsigned h);
        wait_drained();
        write_reg(REG_MAX_ITER, lim);
        write_reg(REG_CANVAS_W, w);
        write_reg(REG_CANVAS_H, h);
    endtask

    initial begin : result_sink
        int stall;
        stall = 0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (hold_len != 0) begin
                m_tready = 1'b0;
                repeat (hold_len - 1) @(negedge clk);
                hold_len = 0;
            end else if (stall != 0) begin
                m_tready = 1'b0;
                stall = stall - 1;
            end else begin
                stall = rx_jitter ? idle_len() : 0;
                m_tready = (stall == 0);
                if (stall != 0)
                    stall = stall - 1;
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_CYCLES) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen)
                idle = 0;
            else
                idle++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        int unsigned lim;
        int unsigned w;
        int unsigned h;
        int          count;
        int          ph;
        int          k;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        rx_jitter = 1'b1;

        // reset settings: corners, origin, left edge, bit patterns
        send_pixel(0, 0);
        send_pixel(1023, 1023);
        send_pixel(64, 32);
        send_pixel(0, 32);
        send_pixel(127, 63);
        send_pixel(1023, 0);
        send_pixel(0, 1023);
        send_pixel(10'h2AA, 10'h155);
        send_pixel(10'h155, 10'h2AA);
        send_pixel(80, 40);

        // full limit: origin never escapes, a far point escapes at level zero
        set_canvas(1023, 1, 1);
        send_pixel(0, 0);
        send_pixel(5, 0);

        set_canvas(1, 1024, 1024);
        send_pixel(512, 512);
        send_pixel(0, 0);

        // no iterations at all
        set_canvas(0, 0, 0);
        send_pixel(0, 0);
        send_pixel(1023, 1023);

        // zero width saturates every coordinate
        set_canvas(20, 0, 2047);
        send_pixel(3, 7);
        send_pixel(1023, 0);

        set_canvas(30, 2047, 2047);
        send_pixel(1023, 1023);
        send_pixel(0, 0);

        for (ph = 0; ph < 11; ph++) begin
            lim = (ph == 3) ? $urandom_range(300, 1023) : $urandom_range(1, 48);
            w = pick_dim();
            h = pick_dim();
            count = (ph == 3) ? 8 : 178;
            set_canvas(lim, w, h);
            tx_jitter = ($urandom_range(0, 3) != 0);
            rx_jitter = ($urandom_range(0, 3) != 0);
            // long output stall while requests keep coming
            if (ph == 5) begin
                @(posedge clk);
                hold_len = HOLD_CYCLES;
                @(negedge clk);
            end
            for (k = 0; k < count; k++) begin
                if (ph == 7 && k == count / 2)
                    wait_drained();
                send_pixel(pick_coord(w), pick_coord(h));
            end
        end

        wait_drained();
        repeat (50) @(negedge clk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[mandelbrot_escape_pixel_colour.f]
rtl/mbe_pkg.sv
rtl/mbe_mul.sv
rtl/mandelbrot_escape_pixel_colour.sv
sim/mandelbrot_pixel_checker.sv
sim/mandelbrot_escape_pixel_colour_test.sv
